// File: hw/rtl/lsc_pkg.sv
// Package for the cursor shape cache: field widths, the cached entry type,
// result codes and reset values. Used by every other file under hw/rtl.
package lsc_pkg;

  localparam int unsigned ENTRIES_DEF = 8;
  localparam int unsigned HANDLE_W    = 64;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned HASH_W      = 64;
  localparam int unsigned AGE_W       = 31;
  localparam int unsigned SLOT_OUT_W  = 3;

  localparam logic [AGE_W-1:0] STALE_AGE_RST = 31'd2000;

  typedef enum logic [2:0] {
    OUT_FRESH = 3'd0,
    OUT_SAME  = 3'd1,
    OUT_REPL  = 3'd2,
    OUT_NEW   = 3'd3,
    OUT_FLUSH = 3'd4
  } outcome_e;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   ltime;
    logic [HASH_W-1:0]   hash;
    logic                valid;
    logic                supp;
  } entry_t;

endpackage

// File: hw/rtl/lsc_cell.sv
// One recency position of the cache: holds an entry and its physical slot,
// compares the held handle against the key. Depends on lsc_pkg.
module lsc_cell #(
  parameter int unsigned SlotW = 3
) (
  input  logic                          clk_i,
  input  logic [lsc_pkg::HANDLE_W-1:0]  key_i,
  input  logic                          shift_i,
  input  logic                          load_i,
  input  lsc_pkg::entry_t               next_entry_i,
  input  logic [SlotW-1:0]              next_slot_i,
  input  lsc_pkg::entry_t               new_entry_i,
  input  logic [SlotW-1:0]              new_slot_i,
  output lsc_pkg::entry_t               entry_o,
  output logic [SlotW-1:0]              slot_o,
  output logic                          match_o
);

  lsc_pkg::entry_t  entry_q;
  logic [SlotW-1:0] slot_q;

  // A load of the most recent entry wins over a shift from the neighbor.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      entry_q <= new_entry_i;
      slot_q  <= new_slot_i;
    end else if (shift_i) begin
      entry_q <= next_entry_i;
      slot_q  <= next_slot_i;
    end
  end

  assign match_o = (entry_q.handle == key_i);
  assign entry_o = entry_q;
  assign slot_o  = slot_q;

endmodule

// File: hw/rtl/lru_shape_cache_with_revalidation.sv
// Cursor shape cache, LRU order kept as a row of cells from least to most recent.
// An accepted input word passes the compare state, then the update state, which writes the output word.
// A new word is taken only once the previous word commits, after the compare-then-shift pass over the cells.
// The update waits while a previous output word is still stalled.
// Reset empties the cache and sets stale_age to 2000; cell contents are not cleared.
module lru_shape_cache_with_revalidation #(
  parameter int unsigned Entries = lsc_pkg::ENTRIES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lsc_pkg::AGE_W-1:0]       cfg_stale_age_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            op_i,
  input  logic [lsc_pkg::HANDLE_W-1:0]    cursor_handle_i,
  input  logic [lsc_pkg::TIME_W-1:0]      now_ticks_i,
  input  logic                            shape_valid_i,
  input  logic                            shape_supported_i,
  input  logic [lsc_pkg::HASH_W-1:0]      shape_hash_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [2:0]                      outcome_o,
  output logic [lsc_pkg::SLOT_OUT_W-1:0]  slot_o,
  output logic                            entry_valid_o,
  output logic                            entry_supported_o,
  output logic                            upload_needed_o,
  output logic                            evicted_o,
  output logic [lsc_pkg::HANDLE_W-1:0]    evicted_handle_o
);

  localparam int unsigned SW = $clog2(Entries);
  localparam int unsigned CW = $clog2(Entries + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_CMP, ST_UPD} state_e;

  state_e state_q;
  logic [lsc_pkg::AGE_W-1:0] stale_age_q;
  logic [CW-1:0] cnt_q, cnt_d;

  // Captured input word.
  logic                          op_q, sv_q, ss_q;
  logic [lsc_pkg::HANDLE_W-1:0]  handle_q;
  logic [lsc_pkg::TIME_W-1:0]    now_q;
  logic [lsc_pkg::HASH_W-1:0]    hash_q;

  // Cell row.
  lsc_pkg::entry_t  cell_entry [Entries];
  logic [SW-1:0]    cell_slot  [Entries];
  logic [Entries-1:0] cell_match, cell_shift, cell_load;
  lsc_pkg::entry_t  new_entry;
  logic [SW-1:0]    new_slot;

  // Compare stage results.
  logic                          hit_d, hit_q;
  logic [SW-1:0]                 pos_d, pos_q;
  lsc_pkg::entry_t               m_d, m_q;
  logic [SW-1:0]                 mslot_d, mslot_q;
  logic [SW-1:0]                 free_d, free_q;
  logic [lsc_pkg::HANDLE_W-1:0]  lru_handle_q;
  logic [SW-1:0]                 lru_slot_q;

  // Update stage.
  logic                          commit, accept;
  logic                          stale, keep, full;
  logic [lsc_pkg::TIME_W-1:0]    age;
  logic                          rm, do_load, evict, upload;
  logic [SW-1:0]                 rp;
  logic [CW-1:0]                 last;
  lsc_pkg::outcome_e             outcome;
  logic [lsc_pkg::HANDLE_W-1:0]  ev_handle;

  // Output register.
  logic                          out_valid_q;
  lsc_pkg::outcome_e             out_outcome_q;
  logic [lsc_pkg::SLOT_OUT_W-1:0] out_slot_q;
  logic                          out_ev_q, out_es_q, out_up_q, out_evict_q;
  logic [lsc_pkg::HANDLE_W-1:0]  out_ehandle_q;

  assign commit      = (state_q == ST_UPD) && !(out_valid_q && out_stall_i);
  assign in_stall_o  = !((state_q == ST_IDLE) || commit);
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = (state_q == ST_IDLE);

  for (genvar p = 0; p < Entries; p++) begin : g_cell
    lsc_pkg::entry_t nxt_entry;
    logic [SW-1:0]   nxt_slot;
    if (p == Entries - 1) begin : g_end
      assign nxt_entry = cell_entry[p];
      assign nxt_slot  = cell_slot[p];
    end else begin : g_mid
      assign nxt_entry = cell_entry[p+1];
      assign nxt_slot  = cell_slot[p+1];
    end
    lsc_cell #(.SlotW(SW)) u_cell (
      .clk_i        (clk_i),
      .key_i        (handle_q),
      .shift_i      (cell_shift[p]),
      .load_i       (cell_load[p]),
      .next_entry_i (nxt_entry),
      .next_slot_i  (nxt_slot),
      .new_entry_i  (new_entry),
      .new_slot_i   (new_slot),
      .entry_o      (cell_entry[p]),
      .slot_o       (cell_slot[p]),
      .match_o      (cell_match[p])
    );
  end

  // Compare pass: first occupied match, and the lowest slot no occupied cell holds.
  always_comb begin
    logic [Entries-1:0] used;
    logic               free_found;
    hit_d      = 1'b0;
    pos_d      = '0;
    m_d        = cell_entry[0];
    mslot_d    = cell_slot[0];
    used       = '0;
    free_d     = '0;
    free_found = 1'b0;
    for (int p = 0; p < Entries; p++) begin
      if (CW'(p) < cnt_q) begin
        used[cell_slot[p]] = 1'b1;
        if (cell_match[p] && !hit_d) begin
          hit_d   = 1'b1;
          pos_d   = SW'(p);
          m_d     = cell_entry[p];
          mslot_d = cell_slot[p];
        end
      end
    end
    for (int i = 0; i < Entries; i++) begin
      if (!used[i] && !free_found) begin
        free_found = 1'b1;
        free_d     = SW'(i);
      end
    end
  end

  assign age   = now_q - m_q.ltime;
  assign stale = !(age < {1'b0, stale_age_q});
  assign keep  = sv_q && ss_q && m_q.supp && (hash_q == m_q.hash);
  assign full  = (cnt_q == CW'(Entries));

  always_comb begin
    outcome   = lsc_pkg::OUT_NEW;
    new_entry = '{handle: handle_q, ltime: now_q, hash: hash_q, valid: sv_q, supp: ss_q};
    new_slot  = free_q;
    rm        = 1'b0;
    rp        = '0;
    last      = cnt_q;
    cnt_d     = cnt_q + CW'(1);
    do_load   = 1'b1;
    evict     = 1'b0;
    ev_handle = '0;
    upload    = sv_q && ss_q;
    priority if (op_q) begin
      outcome   = lsc_pkg::OUT_FLUSH;
      cnt_d     = '0;
      do_load   = 1'b0;
      upload    = 1'b0;
      new_entry = '0;
      new_slot  = '0;
    end else if (hit_q) begin
      rm       = 1'b1;
      rp       = pos_q;
      last     = cnt_q - CW'(1);
      cnt_d    = cnt_q;
      new_slot = mslot_q;
      priority if (!stale) begin
        outcome   = lsc_pkg::OUT_FRESH;
        new_entry = m_q;
        upload    = 1'b0;
      end else if (keep) begin
        outcome         = lsc_pkg::OUT_SAME;
        new_entry       = m_q;
        new_entry.ltime = now_q;
        upload          = 1'b0;
      end else begin
        outcome = lsc_pkg::OUT_REPL;
      end
    end else if (full) begin
      // Miss on a full cache: the least recent cell leaves and its slot is reused.
      rm        = 1'b1;
      rp        = '0;
      last      = cnt_q - CW'(1);
      cnt_d     = cnt_q;
      new_slot  = lru_slot_q;
      evict     = 1'b1;
      ev_handle = lru_handle_q;
    end else begin
      // Miss with room left: the lowest free slot takes the new entry.
      new_slot = free_q;
    end
  end

  always_comb begin
    for (int p = 0; p < Entries; p++) begin
      cell_load[p]  = commit && do_load && (CW'(p) == last);
      cell_shift[p] = commit && rm && (SW'(p) >= rp);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stale_age_q <= lsc_pkg::STALE_AGE_RST;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        stale_age_q <= cfg_stale_age_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) state_q <= ST_CMP;
        end
        ST_CMP: begin
          state_q <= ST_UPD;
        end
        ST_UPD: begin
          if (commit) state_q <= accept ? ST_CMP : ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
      if (commit) begin
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= op_i;
      handle_q <= cursor_handle_i;
      now_q    <= now_ticks_i;
      sv_q     <= shape_valid_i;
      ss_q     <= shape_supported_i;
      hash_q   <= shape_hash_i;
    end
    if (state_q == ST_CMP) begin
      hit_q        <= hit_d;
      pos_q        <= pos_d;
      m_q          <= m_d;
      mslot_q      <= mslot_d;
      free_q       <= free_d;
      lru_handle_q <= cell_entry[0].handle;
      lru_slot_q   <= cell_slot[0];
    end
    if (commit) begin
      out_outcome_q <= outcome;
      out_slot_q    <= lsc_pkg::SLOT_OUT_W'(new_slot);
      out_ev_q      <= new_entry.valid;
      out_es_q      <= new_entry.supp;
      out_up_q      <= upload;
      out_evict_q   <= evict;
      out_ehandle_q <= ev_handle;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign outcome_o         = out_outcome_q;
  assign slot_o            = out_slot_q;
  assign entry_valid_o     = out_ev_q;
  assign entry_supported_o = out_es_q;
  assign upload_needed_o   = out_up_q;
  assign evicted_o         = out_evict_q;
  assign evicted_handle_o  = out_ehandle_q;

endmodule

// File: hw/rtl/lsc_check.sv
// Port-level checks on the cursor shape cache results, bound to the top level.
// Depends on lsc_pkg and lru_shape_cache_with_revalidation.
module lsc_check (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic [2:0]                      outcome_o,
  input logic [lsc_pkg::SLOT_OUT_W-1:0]  slot_o,
  input logic                            entry_valid_o,
  input logic                            entry_supported_o,
  input logic                            upload_needed_o,
  input logic                            evicted_o,
  input logic [lsc_pkg::HANDLE_W-1:0]    evicted_handle_o
);

  // Only a new load on a full cache drops an entry.
  a_evict_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && evicted_o |-> outcome_o == lsc_pkg::OUT_NEW)
    else $error("eviction reported on an outcome other than a new load");

  a_evict_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !evicted_o |-> evicted_handle_o == '0)
    else $error("evicted handle nonzero without an eviction");

  // An upload follows only an insert of a valid and supported shape.
  a_upload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && upload_needed_o |->
      (outcome_o == lsc_pkg::OUT_REPL || outcome_o == lsc_pkg::OUT_NEW) &&
      entry_valid_o && entry_supported_o)
    else $error("upload requested without a fresh valid, supported insert");

  a_flush_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && outcome_o == lsc_pkg::OUT_FLUSH |->
      slot_o == '0 && !entry_valid_o && !entry_supported_o && !upload_needed_o &&
      !evicted_o)
    else $error("flush word carries nonzero fields");

  a_outcome_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> outcome_o <= lsc_pkg::OUT_FLUSH)
    else $error("outcome code out of range");

endmodule

bind lru_shape_cache_with_revalidation lsc_check u_lsc_check (.*);
